// ===== sv/hbb_pkg.sv =====
// shared types, constants and tables for the horizontal box blur row core
`default_nettype none

package hbb_pkg;

  localparam int MAX_RADIUS    = 48;
  localparam int MAX_ROW_WIDTH = 4096;

  localparam int CHAN_W    = 8;
  localparam int RADIUS_W  = 6;
  localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int TAKEN_W   = $clog2(MAX_ROW_WIDTH + 2);
  localparam int SUM_W     = $clog2(WIN_DEPTH * 255 + 1);
  localparam int MULT_W    = 15;
  localparam int PROD_W    = SUM_W + MULT_W;
  localparam int FRAC_BITS = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic              row_end_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              row_end_out;
    logic              overlong_row;
  } pixel_out_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // one classified input beat, front to back
  typedef struct packed {
    pixel_t              pixel;
    logic                first;
    logic                last;
    logic                overlong;
    logic [RADIUS_W-1:0] radius;
  } cmd_t;

  // one element of the edge-padded stream, sequencer to accumulator
  typedef struct packed {
    pixel_t            pixel;
    logic [WIN_AW-1:0] ptr;
    logic              start;
    logic              old_valid;
    logic              emit;
    logic              last;
    logic              overlong;
    logic [MULT_W-1:0] mult;
  } elem_t;

  // floor(65536 / (2r + 1)), indexed by radius; entry zero is never used
  localparam logic [MULT_W-1:0] MULT_TABLE [64] = '{
    15'd0,
    15'(65536 / 3),   15'(65536 / 5),   15'(65536 / 7),   15'(65536 / 9),
    15'(65536 / 11),  15'(65536 / 13),  15'(65536 / 15),  15'(65536 / 17),
    15'(65536 / 19),  15'(65536 / 21),  15'(65536 / 23),  15'(65536 / 25),
    15'(65536 / 27),  15'(65536 / 29),  15'(65536 / 31),  15'(65536 / 33),
    15'(65536 / 35),  15'(65536 / 37),  15'(65536 / 39),  15'(65536 / 41),
    15'(65536 / 43),  15'(65536 / 45),  15'(65536 / 47),  15'(65536 / 49),
    15'(65536 / 51),  15'(65536 / 53),  15'(65536 / 55),  15'(65536 / 57),
    15'(65536 / 59),  15'(65536 / 61),  15'(65536 / 63),  15'(65536 / 65),
    15'(65536 / 67),  15'(65536 / 69),  15'(65536 / 71),  15'(65536 / 73),
    15'(65536 / 75),  15'(65536 / 77),  15'(65536 / 79),  15'(65536 / 81),
    15'(65536 / 83),  15'(65536 / 85),  15'(65536 / 87),  15'(65536 / 89),
    15'(65536 / 91),  15'(65536 / 93),  15'(65536 / 95),  15'(65536 / 97),
    15'(65536 / 99),  15'(65536 / 101), 15'(65536 / 103), 15'(65536 / 105),
    15'(65536 / 107), 15'(65536 / 109), 15'(65536 / 111), 15'(65536 / 113),
    15'(65536 / 115), 15'(65536 / 117), 15'(65536 / 119), 15'(65536 / 121),
    15'(65536 / 123), 15'(65536 / 125), 15'(65536 / 127)
  };

  function automatic logic [RADIUS_W-1:0] clamp_radius(input logic [RADIUS_W-1:0] r);
    logic [RADIUS_W-1:0] c;
    if (r == '0) begin
      c = RADIUS_W'(1);
    end else if (r > RADIUS_W'(MAX_RADIUS)) begin
      c = RADIUS_W'(MAX_RADIUS);
    end else begin
      c = r;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hbb_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module hbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/hbb_front.sv =====
// front end: radius register, row pixel count and beat classification
`default_nettype none

module hbb_front import hbb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_enable,
  input  logic [RADIUS_W-1:0] cfg_write_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  pixel_in_t           in_data,
  input  logic                q_full,
  output logic                q_push,
  output cmd_t                q_cmd
);

  logic [RADIUS_W-1:0] radius;
  logic [TAKEN_W-1:0]  taken;
  logic [TAKEN_W-1:0]  taken_next;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // count saturates one past the row width limit
  assign taken_next = (taken > TAKEN_W'(MAX_ROW_WIDTH)) ? taken : taken + 1'b1;

  always_comb begin
    q_cmd.pixel.red   = in_data.red_in;
    q_cmd.pixel.green = in_data.green_in;
    q_cmd.pixel.blue  = in_data.blue_in;
    q_cmd.first       = (taken == '0);
    q_cmd.last        = in_data.row_end_in;
    q_cmd.overlong    = (taken_next > TAKEN_W'(MAX_ROW_WIDTH));
    q_cmd.radius      = clamp_radius(radius);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_W'(1);
      taken  <= '0;
    end else begin
      if (cfg_write_enable) begin
        radius <= cfg_write_data;
      end
      if (q_push) begin
        taken <= in_data.row_end_in ? '0 : taken_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/hbb_queue.sv =====
// short command queue between front end and back end
`default_nettype none

module hbb_queue import hbb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");
  a_push_not_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
`endif

endmodule

`default_nettype wire

// ===== sv/hbb_seq.sv =====
// back end sequencer: expands row beats into the edge-padded pixel stream
`default_nettype none

module hbb_seq import hbb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  q_empty,
  input  cmd_t  q_head,
  output logic  q_pop,
  output logic  el_valid,
  output elem_t el
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LEFT  = 4'b0010,
    ST_PIX   = 4'b0100,
    ST_RIGHT = 4'b1000
  } seq_state_t;

  seq_state_t          state, state_next;
  cmd_t                cur, cur_next;
  logic [RADIUS_W-1:0] pad_cnt, pad_cnt_next;
  logic [RADIUS_W-1:0] row_radius, row_radius_next;
  logic [FILL_W-1:0]   fill, fill_next;
  logic [WIN_AW-1:0]   ptr, ptr_next;
  logic [RADIUS_W-1:0] rad;
  logic [FILL_W-1:0]   win_len;
  logic                issue;
  logic                pop;
  logic                row_done;

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    pad_cnt_next    = pad_cnt;
    row_radius_next = row_radius;
    rad             = row_radius;
    issue           = 1'b0;
    pop             = 1'b0;
    row_done        = 1'b0;
    el.pixel        = cur.pixel;
    el.overlong     = cur.overlong;
    el.last         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pop         = 1'b1;
          issue       = 1'b1;
          cur_next    = q_head;
          el.pixel    = q_head.pixel;
          el.overlong = q_head.overlong;
          if (q_head.first) begin
            // first pad goes out now, the radius takes effect from here
            rad             = q_head.radius;
            row_radius_next = q_head.radius;
            if (q_head.radius == RADIUS_W'(1)) begin
              state_next = ST_PIX;
            end else begin
              state_next   = ST_LEFT;
              pad_cnt_next = q_head.radius - 1'b1;
            end
          end else if (q_head.last) begin
            state_next   = ST_RIGHT;
            pad_cnt_next = row_radius;
          end
        end
      end
      ST_LEFT: begin
        issue        = 1'b1;
        pad_cnt_next = pad_cnt - 1'b1;
        if (pad_cnt == RADIUS_W'(1)) begin
          state_next = ST_PIX;
        end
      end
      ST_PIX: begin
        issue = 1'b1;
        if (cur.last) begin
          state_next   = ST_RIGHT;
          pad_cnt_next = row_radius;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RIGHT: begin
        issue = 1'b1;
        if (pad_cnt == RADIUS_W'(1)) begin
          el.last    = 1'b1;
          row_done   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          pad_cnt_next = pad_cnt - 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // window bookkeeping over the padded stream, ring of 2r+1 slots
    win_len      = FILL_W'({rad, 1'b1});
    el.ptr       = ptr;
    el.start     = (fill == '0);
    el.old_valid = (fill == win_len);
    el.emit      = (fill >= win_len - 1'b1);
    el.mult      = MULT_TABLE[rad];
    fill_next    = fill;
    ptr_next     = ptr;
    if (issue) begin
      if (fill != win_len) begin
        fill_next = fill + 1'b1;
      end
      ptr_next = (ptr == WIN_AW'(win_len - 1'b1)) ? '0 : ptr + 1'b1;
      if (row_done) begin
        fill_next = '0;
        ptr_next  = '0;
      end
    end
  end

  assign el_valid = issue;
  assign q_pop    = pop && adv;

  always_ff @(posedge clk) begin
    if (adv) begin
      cur <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pad_cnt    <= '0;
      row_radius <= RADIUS_W'(1);
      fill       <= '0;
      ptr        <= '0;
    end else if (adv) begin
      state      <= state_next;
      pad_cnt    <= pad_cnt_next;
      row_radius <= row_radius_next;
      fill       <= fill_next;
      ptr        <= ptr_next;
    end
  end

`ifndef SYNTHESIS
  a_pads_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEFT || state == ST_RIGHT) |-> pad_cnt != '0)
    else $error("pad phase entered with no pads left");
`endif

endmodule

`default_nettype wire

// ===== sv/hbb_accum.sv =====
// back end datapath: window ring, running sums, scaling and output register
`default_nettype none

module hbb_accum import hbb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  output logic       adv,
  input  logic       el_valid,
  input  elem_t      el,
  output logic       out_valid,
  input  logic       out_stall,
  output pixel_out_t out_data
);

  elem_t             s1;
  logic              s1_valid;
  logic [$bits(pixel_t)-1:0] rd_data;
  pixel_t            old_px;
  logic [SUM_W-1:0]  red_sum, green_sum, blue_sum;
  logic [SUM_W-1:0]  red_sum_next, green_sum_next, blue_sum_next;
  logic              s2_valid;
  logic              s2_last;
  logic              s2_overlong;
  logic [MULT_W-1:0] s2_mult;
  logic [PROD_W-1:0] red_prod, green_prod, blue_prod;

  function automatic logic [SUM_W-1:0] sum_step(
    input logic [SUM_W-1:0]  sum,
    input logic [CHAN_W-1:0] add,
    input logic [CHAN_W-1:0] sub,
    input logic              start,
    input logic              old_valid
  );
    logic [SUM_W-1:0] base;
    logic [SUM_W-1:0] drop;
    base = start ? '0 : sum;
    drop = old_valid ? SUM_W'(sub) : '0;
    return base + SUM_W'(add) - drop;
  endfunction

  // whole back pipeline moves together
  assign adv = !out_valid || !out_stall;

  hbb_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (WIN_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (adv && s1_valid),
    .wr_addr (s1.ptr),
    .wr_data (s1.pixel),
    .rd_en   (adv && el_valid),
    .rd_addr (el.ptr),
    .rd_data (rd_data)
  );

  assign old_px = rd_data;

  always_comb begin
    red_sum_next   = sum_step(red_sum, s1.pixel.red, old_px.red, s1.start, s1.old_valid);
    green_sum_next = sum_step(green_sum, s1.pixel.green, old_px.green, s1.start,
                              s1.old_valid);
    blue_sum_next  = sum_step(blue_sum, s1.pixel.blue, old_px.blue, s1.start, s1.old_valid);
  end

  // the sum registers hold the sums of the beat in stage two whenever that beat is valid
  assign red_prod   = red_sum * s2_mult;
  assign green_prod = green_sum * s2_mult;
  assign blue_prod  = blue_sum * s2_mult;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1          <= el;
      s2_last     <= s1.last;
      s2_overlong <= s1.overlong;
      s2_mult     <= s1.mult;
      out_data.red_out      <= red_prod[FRAC_BITS +: CHAN_W];
      out_data.green_out    <= green_prod[FRAC_BITS +: CHAN_W];
      out_data.blue_out     <= blue_prod[FRAC_BITS +: CHAN_W];
      out_data.row_end_out  <= s2_last;
      out_data.overlong_row <= s2_overlong;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      red_sum   <= '0;
      green_sum <= '0;
      blue_sum  <= '0;
    end else if (adv) begin
      s1_valid  <= el_valid;
      s2_valid  <= s1_valid && s1.emit;
      out_valid <= s2_valid;
      if (s1_valid) begin
        red_sum   <= red_sum_next;
        green_sum <= green_sum_next;
        blue_sum  <= blue_sum_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    red_sum <= SUM_W'(WIN_DEPTH * 255) && green_sum <= SUM_W'(WIN_DEPTH * 255)
    && blue_sum <= SUM_W'(WIN_DEPTH * 255))
    else $error("window sum beyond full window of white pixels");
  a_old_only_mid_row: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.old_valid |-> !s1.start)
    else $error("ring read subtracted at row start");
`endif

endmodule

`default_nettype wire

// ===== sv/horizontal_box_blur_row_core.sv =====
// top level of the horizontal box blur row core
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------
//  input   | in_valid / in_stall    | in_data  (pixel_in_t), one pixel
//  output  | out_valid / out_stall  | out_data (pixel_out_t), one pixel
//  config  | cfg_write_enable       | cfg_write_data (radius, 6 bits)
//
// the back sequencer issues one element per pixel plus r pad elements at each
// row edge, so a row of n pixels becomes n + 2r elements; a result passes
// through stage one, stage two and the output register after the sequencer
// issues the beat that completes its window. reset is synchronous; the window
// ring needs no clearing pass. out_stall with out_valid high freezes the whole
// back pipeline, and in_stall rises once the four-entry command queue is full.
`default_nettype none

module horizontal_box_blur_row_core import hbb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_enable,
  input  logic [RADIUS_W-1:0] cfg_write_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  pixel_in_t           in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pixel_out_t          out_data
);

  logic  q_full;
  logic  q_push;
  cmd_t  q_cmd;
  logic  q_pop;
  logic  q_empty;
  cmd_t  q_head;
  logic  adv;
  logic  el_valid;
  elem_t el;

  hbb_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  hbb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  hbb_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .el_valid (el_valid),
    .el       (el)
  );

  hbb_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .el_valid  (el_valid),
    .el        (el),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== bench/blur_row_checker.sv =====
// checker that predicts every blurred pixel of the row core and compares it with the output
`timescale 1ns / 1ps

module blur_row_checker import hbb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_enable,
  input  logic [RADIUS_W-1:0] cfg_write_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  pixel_in_t           in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pixel_out_t          out_data,
  input  logic                run_done,
  output int                  fail_count,
  output int                  beats_due,
  output int                  beats_checked
);

  pixel_t              row_ring [WIN_DEPTH];
  int                  newest = WIN_DEPTH - 1;
  logic [TAKEN_W-1:0]  taken = '0;
  pixel_t              first_px = '0;
  logic [RADIUS_W-1:0] radius_reg = RADIUS_W'(1);
  logic [RADIUS_W-1:0] row_radius = RADIUS_W'(1);
  pixel_out_t          blurred_due [$];
  int                  errors = 0;
  int                  checked = 0;
  bit                  leftovers_done = 1'b0;

  task automatic report(input string what);
    if (errors < 25) $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // pixel d places behind the newest; before the row start it reads the first pixel
  function automatic pixel_t pixel_back(input int d);
    if (d + 1 > int'(taken)) return first_px;
    return row_ring[(newest + WIN_DEPTH - d) % WIN_DEPTH];
  endfunction

  function automatic logic [CHAN_W-1:0] scale(input logic [SUM_W-1:0] sum,
                                              input logic [MULT_W-1:0] mult);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(mult);
    return prod[FRAC_BITS +: CHAN_W];
  endfunction

  // blurred pixel whose centre sits e places behind the newest
  function automatic pixel_out_t blur_at(input int e, input bit last);
    logic [SUM_W-1:0]  sum_r;
    logic [SUM_W-1:0]  sum_g;
    logic [SUM_W-1:0]  sum_b;
    logic [MULT_W-1:0] mult;
    pixel_t            px;
    pixel_out_t        o;
    int                d;
    int                r;
    r     = int'(row_radius);
    mult  = MULT_W'(65536 / (2 * r + 1));
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int j = 0; j <= 2 * r; j++) begin
      d     = (e + j >= r) ? e + j - r : 0;
      px    = pixel_back(d);
      sum_r = sum_r + SUM_W'(px.red);
      sum_g = sum_g + SUM_W'(px.green);
      sum_b = sum_b + SUM_W'(px.blue);
    end
    o.red_out      = scale(sum_r, mult);
    o.green_out    = scale(sum_g, mult);
    o.blue_out     = scale(sum_b, mult);
    o.row_end_out  = last;
    o.overlong_row = (int'(taken) > MAX_ROW_WIDTH);
    return o;
  endfunction

  task automatic take_pixel(input pixel_in_t p);
    pixel_t px;
    int     cnt;
    px.red   = p.red_in;
    px.green = p.green_in;
    px.blue  = p.blue_in;
    if (taken == '0) begin
      // radius is latched on the first beat of each row, clamped to the legal span
      if (radius_reg == '0) begin
        row_radius = RADIUS_W'(1);
      end else if (int'(radius_reg) > MAX_RADIUS) begin
        row_radius = RADIUS_W'(MAX_RADIUS);
      end else begin
        row_radius = radius_reg;
      end
      first_px = px;
    end
    newest = (newest + 1) % WIN_DEPTH;
    row_ring[newest] = px;
    if (int'(taken) <= MAX_ROW_WIDTH) taken = taken + 1'b1;
    if (int'(taken) - 1 >= int'(row_radius)) blurred_due.push_back(blur_at(int'(row_radius), 1'b0));
    if (p.row_end_in) begin
      // flush the tail of the row; short rows give all of their pixels here
      cnt = (int'(taken) - 1 < int'(row_radius)) ? int'(taken) : int'(row_radius);
      for (int e = cnt; e > 0; e--) blurred_due.push_back(blur_at(e - 1, e == 1));
      taken = '0;
    end
  endtask

  task automatic check_beat(input pixel_out_t got);
    pixel_out_t want;
    int         idx;
    idx = checked;
    checked++;
    if (blurred_due.size() == 0) begin
      report($sformatf("output beat %0d came with nothing expected", idx));
      return;
    end
    want = blurred_due.pop_front();
    if (got.red_out !== want.red_out)
      report($sformatf("beat %0d red %0d, want %0d", idx, got.red_out, want.red_out));
    if (got.green_out !== want.green_out)
      report($sformatf("beat %0d green %0d, want %0d", idx, got.green_out, want.green_out));
    if (got.blue_out !== want.blue_out)
      report($sformatf("beat %0d blue %0d, want %0d", idx, got.blue_out, want.blue_out));
    if (got.row_end_out !== want.row_end_out)
      report($sformatf("beat %0d row end %b, want %b", idx, got.row_end_out, want.row_end_out));
    if (got.overlong_row !== want.overlong_row)
      report($sformatf("beat %0d overlong %b, want %b", idx, got.overlong_row, want.overlong_row));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      blurred_due.delete();
      taken      = '0;
      first_px   = '0;
      radius_reg = RADIUS_W'(1);
      row_radius = RADIUS_W'(1);
      newest     = WIN_DEPTH - 1;
    end else begin
      if (out_valid && !out_stall) check_beat(out_data);
      if (cfg_write_enable) radius_reg = cfg_write_data;
      if (in_valid && !in_stall) take_pixel(in_data);
      if (run_done && !leftovers_done) begin
        leftovers_done = 1'b1;
        while (blurred_due.size() > 0) begin
          report("expected beat never came out");
          void'(blurred_due.pop_front());
        end
      end
    end
    fail_count    <= errors;
    beats_due     <= blurred_due.size();
    beats_checked <= checked;
  end

endmodule

// ===== bench/tb_horizontal_box_blur_row_core.sv =====
// top of the box blur row core testbench: clock, reset, pixel rows, radius writes and verdict
`timescale 1ns / 1ps

module tb_horizontal_box_blur_row_core;
  import hbb_pkg::*;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int SETTLE       = 2 * MAX_RADIUS + 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int PRESSURE_ROW = 20;
  localparam int RANDOM_ITEMS = 86;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_write_enable = 1'b0;
  logic [RADIUS_W-1:0] cfg_write_data = '0;
  logic                in_valid = 1'b0;
  pixel_in_t           in_data = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  pixel_out_t          out_data;

  logic hold_req = 1'b0;
  logic holding = 1'b0;
  logic calm = 1'b0;
  logic run_done = 1'b0;

  int fail_count;
  int beats_due;
  int beats_checked;
  int pixels_sent = 0;
  int rows_sent = 0;
  int radius_writes = 0;
  int cycle_count = 0;

  horizontal_box_blur_row_core u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data)
  );

  blur_row_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .run_done         (run_done),
    .fail_count       (fail_count),
    .beats_due        (beats_due),
    .beats_checked    (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** horizontal_box_blur_row_core: FAILED **");
    $finish;
  end

  // mostly short gaps, now and then a long one; none at all in calm phases
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_channel();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return '0;
    if (roll < 24) return '1;
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  function automatic pixel_in_t px(input int r, input int g, input int b, input bit last);
    pixel_in_t p;
    p.red_in     = CHAN_W'(r);
    p.green_in   = CHAN_W'(g);
    p.blue_in    = CHAN_W'(b);
    p.row_end_in = last;
    return p;
  endfunction

  // output side: random stall, plus one long hold-off on request
  initial begin : receiver
    int  hold;
    bit  held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
        holding <= 1'b1;
      end else begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      holding   <= 1'b0;
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // offers one beat and returns on the edge that takes it; valid stays up for the next beat
  task automatic send_pixel(input pixel_in_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
    if (p.row_end_in) rows_sent++;
  endtask

  task automatic send_row(input int len);
    for (int i = 0; i < len; i++)
      send_pixel(px(pick_channel(), pick_channel(), pick_channel(), i == len - 1));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_radius(input int v);
    cfg_write_data   <= RADIUS_W'(v);
    cfg_write_enable <= 1'b1;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    @(posedge clk);
    radius_writes++;
  endtask

  function automatic int pick_radius();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return $urandom_range(1, 3);
    if (roll < 65) return $urandom_range(4, 12);
    if (roll < 82) return $urandom_range(13, MAX_RADIUS);
    if (roll < 88) return 0;
    return $urandom_range(MAX_RADIUS + 1, 63);
  endfunction

  function automatic int pick_row_len(input int eff);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return $urandom_range(1, eff);
    if (roll < 70) return $urandom_range(eff + 1, 2 * eff + 3);
    return $urandom_range(1, 8);
  endfunction

  initial begin : stimulus
    int v;
    int eff;
    int target;
    int phase_items;
    int random_items;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset radius: single pixel row, two pixel row, row of exactly 2r+2
    send_pixel(px(255, 255, 255, 1'b1));
    send_pixel(px(0, 0, 0, 1'b0));
    send_pixel(px(255, 0, 255, 1'b1));
    send_pixel(px(255, 0, 0, 1'b0));
    send_pixel(px(0, 255, 0, 1'b0));
    send_pixel(px(0, 0, 255, 1'b0));
    send_pixel(px(255, 255, 255, 1'b1));
    drain();

    // zero clamps up to one
    set_radius(0);
    send_pixel(px(128, 64, 32, 1'b0));
    send_pixel(px(1, 2, 4, 1'b0));
    send_pixel(px(254, 253, 251, 1'b1));
    drain();

    // top of the field clamps down to the largest radius; row shorter than the radius
    set_radius(63);
    for (int i = 0; i < 5; i++) send_pixel(px(i * 60, 255 - i * 50, (i % 2) * 255, i == 4));
    drain();

    set_radius(MAX_RADIUS);
    send_pixel(px(255, 255, 255, 1'b0));
    send_pixel(px(0, 0, 0, 1'b0));
    send_pixel(px(255, 255, 255, 1'b1));
    drain();

    set_radius(2);
    for (int i = 0; i < 6; i++) send_pixel(px((i % 2) * 255, ((i + 1) % 2) * 255, i * 51, i == 5));
    drain();

    // long output hold-off while the sender keeps offering, so the block backs up
    set_radius(1);
    hold_req <= 1'b1;
    wait (holding);
    send_row(PRESSURE_ROW);
    drain();

    // random phases, each with its own radius and rows of mixed length
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      v = pick_radius();
      eff = (v == 0) ? 1 : (v > MAX_RADIUS) ? MAX_RADIUS : v;
      set_radius(v);
      calm <= ($urandom_range(0, 3) == 0);
      target = $urandom_range(15, 35);
      if (target > RANDOM_ITEMS - random_items) target = RANDOM_ITEMS - random_items;
      phase_items = 0;
      while (phase_items < target) begin
        v = pick_row_len(eff);
        // the last row is cut short to stay within the pixel budget
        if (v > RANDOM_ITEMS - random_items - phase_items)
          v = RANDOM_ITEMS - random_items - phase_items;
        send_row(v);
        phase_items += v;
      end
      random_items += phase_items;
      drain();
    end

    run_done <= 1'b1;
    @(posedge clk);
    @(posedge clk);

    $display("covered %0d rows and %0d pixels over %0d radius writes", rows_sent, pixels_sent,
             radius_writes);
    $display("%0d blurred beats checked, with a long output hold-off that backed up the input",
             beats_checked);
    if (fail_count == 0) begin
      $display("** horizontal_box_blur_row_core: PASSED **");
    end else begin
      $display("** horizontal_box_blur_row_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/hbb_pkg.sv
sv/hbb_ram.sv
sv/hbb_front.sv
sv/hbb_queue.sv
sv/hbb_seq.sv
sv/hbb_accum.sv
sv/horizontal_box_blur_row_core.sv
bench/blur_row_checker.sv
bench/tb_horizontal_box_blur_row_core.sv
